@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define ASSERT_IMPLY(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Check that a trigger implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ivdr_pkg.sv @@
// ---------------------------------------------------------------------------
// ivdr_pkg
// Widths, register indexes, reset values and saturation helper for the
// vertical dead reckoning block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ivdr_pkg;

    // Field and datapath widths
    localparam int unsigned DataW    = 32;
    localparam int unsigned SumW     = 48;
    localparam int unsigned CountW   = 16;
    localparam int unsigned WeightW  = 16;
    localparam int unsigned StepW    = 16;
    localparam int unsigned BandW    = 31;
    localparam int unsigned AccW     = 64;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned MulSteps = WeightW;
    localparam int unsigned DivSteps = SumW;
    localparam int unsigned StepCntW = $clog2(DivSteps);

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_GRAVITY = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_WEIGHT  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_STEP    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BAND    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BIAS_N  = 3'd4;

    // Register reset values
    localparam logic signed [DataW-1:0] GRAVITY_RST = -32'sd642689;
    localparam logic [WeightW-1:0]      WEIGHT_RST  = 16'd13107;
    localparam logic [StepW-1:0]        STEP_RST    = 16'd655;
    localparam logic [BandW-1:0]        BAND_RST    = 31'd66;
    localparam logic [CountW-1:0]       BIAS_N_RST  = 16'd100;

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] x);
        logic signed [AccW-1:0] hi;
        logic signed [AccW-1:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[DataW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ivdr_if.sv @@
// ---------------------------------------------------------------------------
// ivdr channel interfaces
// Valid/ready channels for samples, results and register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ivdr_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [ivdr_pkg::DataW-1:0]   accel_z;

    modport source (output valid, output accel_z, input ready);
    modport sink   (input valid, input accel_z, output ready);
endinterface

interface ivdr_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ivdr_pkg::DataW-1:0]   height;
    logic signed [ivdr_pkg::DataW-1:0]   velocity;
    logic                                calibrated;
    logic                                integrated;

    modport source (output valid, output height, output velocity, output calibrated,
                    output integrated, input ready);
    modport sink   (input valid, input height, input velocity, input calibrated,
                    input integrated, output ready);
endinterface

interface ivdr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ivdr_pkg::CfgIdxW-1:0]        index;
    logic [ivdr_pkg::DataW-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/imu_vertical_dead_reckoning_top.sv @@
// ---------------------------------------------------------------------------
// imu_vertical_dead_reckoning_top
// Vertical dead reckoning: gravity and bias removal, low-pass, deadband and
// double integration of one accelerometer axis in Q16.16.
// ---------------------------------------------------------------------------
// One sample is worked on at a time and yields exactly one result item. The
// arithmetic runs on a shift-add multiplier that retires one multiplier bit
// per cycle and a restoring divider that retires one quotient bit per cycle.
// A new sample is accepted in the cycle after the previous result is
// registered, even while that result still waits in the output register.
// Register writes are taken in any cycle and belong between items.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imu_vertical_dead_reckoning_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    ivdr_sample_if.sink        i_sample,
    ivdr_result_if.source      o_result,
    ivdr_cfg_if.sink           i_cfg
);

    localparam int unsigned DataW    = ivdr_pkg::DataW;
    localparam int unsigned SumW     = ivdr_pkg::SumW;
    localparam int unsigned CountW   = ivdr_pkg::CountW;
    localparam int unsigned AccW     = ivdr_pkg::AccW;
    localparam int unsigned StepCntW = ivdr_pkg::StepCntW;
    localparam int unsigned DhW      = AccW - 17;

    localparam logic [StepCntW-1:0] MulLast = StepCntW'(ivdr_pkg::MulSteps - 1);
    localparam logic [StepCntW-1:0] DivLast = StepCntW'(ivdr_pkg::DivSteps - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SUB, S_PREP, S_DIV_LOAD, S_DIV, S_DIV_FIN, S_DIFF,
        S_MUL, S_POST, S_BAND, S_VEL, S_HGT, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_FILT, OP_DV, OP_VDT, OP_P2
    } t_op;

    // Configuration registers
    logic signed [DataW-1:0]             r_gravity;
    logic [ivdr_pkg::WeightW-1:0]        r_weight;
    logic [ivdr_pkg::StepW-1:0]          r_step;
    logic [ivdr_pkg::BandW-1:0]          r_band;
    logic [CountW-1:0]                   r_bias_n;

    // Filter and integrator state
    t_state                              r_state;
    t_op                                 r_op;
    logic [CountW-1:0]                   r_count;
    logic signed [SumW-1:0]              r_sum;
    logic signed [DataW-1:0]             r_bias;
    logic signed [DataW-1:0]             r_filt;
    logic signed [DataW-1:0]             r_vel;
    logic signed [DataW-1:0]             r_hgt;

    // Working registers
    logic signed [DataW-1:0]             r_x;
    logic signed [DataW-1:0]             r_a;
    logic signed [DataW-1:0]             r_c;
    logic signed [AccW-1:0]              r_mcand;
    logic [ivdr_pkg::WeightW-1:0]        r_mplier;
    logic signed [AccW-1:0]              r_acc;
    logic [StepCntW-1:0]                 r_bit;
    logic [SumW-1:0]                     r_dvd;
    logic [CountW-1:0]                   r_rem;
    logic [CountW-1:0]                   r_divisor;
    logic                                r_neg;
    logic signed [SumW-1:0]              r_prod;
    logic signed [AccW-1:0]              r_t1;
    logic signed [DataW:0]               r_dv;
    logic signed [DhW-1:0]               r_dh;
    logic                                r_cal;
    logic                                r_integ;

    // Output register
    logic                                r_out_valid;
    logic signed [DataW-1:0]             r_out_hgt;
    logic signed [DataW-1:0]             r_out_vel;
    logic                                r_out_cal;
    logic                                r_out_integ;

    // Combinational datapath
    logic                                in_take;
    logic                                out_take;
    logic signed [AccW-1:0]              diff_xg;
    logic signed [AccW-1:0]              diff_ab;
    logic signed [SumW-1:0]              n_sum;
    logic signed [DataW:0]               diff_cf;
    logic [CountW:0]                     div_trial;
    logic                                div_qbit;
    logic signed [DataW:0]               filt_ext;
    logic [DataW:0]                      filt_mag;
    logic signed [AccW-1:0]              dv_full;
    logic signed [AccW-1:0]              dh_full;
    logic signed [DataW-1:0]             n_vel;
    logic signed [DataW-1:0]             n_hgt;

    assign in_take  = i_sample.valid & i_sample.ready;
    assign out_take = r_out_valid & o_result.ready;

    assign i_sample.ready      = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_result.valid      = r_out_valid;
    assign o_result.height     = r_out_hgt;
    assign o_result.velocity   = r_out_vel;
    assign o_result.calibrated = r_out_cal;
    assign o_result.integrated = r_out_integ;

    // Arithmetic helpers for the sequencer
    always_comb begin
        diff_xg   = {{(AccW-DataW){r_x[DataW-1]}}, r_x}
                  - {{(AccW-DataW){r_gravity[DataW-1]}}, r_gravity};
        diff_ab   = {{(AccW-DataW){r_a[DataW-1]}}, r_a}
                  - {{(AccW-DataW){r_bias[DataW-1]}}, r_bias};
        n_sum     = r_sum + {{(SumW-DataW){r_a[DataW-1]}}, r_a};
        diff_cf   = {r_c[DataW-1], r_c} - {r_filt[DataW-1], r_filt};
        div_trial = {r_rem, r_dvd[SumW-1]};
        div_qbit  = (div_trial >= {1'b0, r_divisor});
        filt_ext  = {r_filt[DataW-1], r_filt};
        filt_mag  = filt_ext[DataW] ? (DataW+1)'(-filt_ext) : filt_ext;
        dv_full   = r_acc + 64'sd32768;
        dh_full   = r_t1 + (r_acc >>> 16);
        n_vel     = ivdr_pkg::sat32({{(AccW-DataW){r_vel[DataW-1]}}, r_vel}
                  + {{(AccW-DataW-1){r_dv[DataW]}}, r_dv});
        n_hgt     = ivdr_pkg::sat32({{(AccW-DataW){r_hgt[DataW-1]}}, r_hgt}
                  + {{(AccW-DhW){r_dh[DhW-1]}}, r_dh});
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= ivdr_pkg::GRAVITY_RST;
            r_weight  <= ivdr_pkg::WEIGHT_RST;
            r_step    <= ivdr_pkg::STEP_RST;
            r_band    <= ivdr_pkg::BAND_RST;
            r_bias_n  <= ivdr_pkg::BIAS_N_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ivdr_pkg::REG_GRAVITY: r_gravity <= i_cfg.data;
                ivdr_pkg::REG_WEIGHT:  r_weight  <= i_cfg.data[ivdr_pkg::WeightW-1:0];
                ivdr_pkg::REG_STEP:    r_step    <= i_cfg.data[ivdr_pkg::StepW-1:0];
                ivdr_pkg::REG_BAND:    r_band    <= i_cfg.data[ivdr_pkg::BandW-1:0];
                ivdr_pkg::REG_BIAS_N:  r_bias_n  <= i_cfg.data[CountW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_FILT;
            r_count     <= '0;
            r_sum       <= '0;
            r_bias      <= '0;
            r_filt      <= '0;
            r_vel       <= '0;
            r_hgt       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output item once taken, unless the done state refills it
            if (out_take && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_x     <= i_sample.accel_z;
                        r_state <= S_SUB;
                    end
                end

                // Remove gravity
                S_SUB: begin
                    r_a     <= ivdr_pkg::sat32(diff_xg);
                    r_state <= S_PREP;
                end

                // Either accumulate towards the bias or remove it
                S_PREP: begin
                    if (r_count < r_bias_n) begin
                        r_sum     <= n_sum;
                        r_divisor <= r_count + 1'b1;
                        r_count   <= r_count + 1'b1;
                        r_cal     <= 1'b0;
                        r_integ   <= 1'b0;
                        r_state   <= S_DIV_LOAD;
                    end else begin
                        r_c     <= ivdr_pkg::sat32(diff_ab);
                        r_cal   <= 1'b1;
                        r_integ <= 1'b0;
                        r_state <= S_DIFF;
                    end
                end

                // Divide the magnitude, restore the sign afterwards
                S_DIV_LOAD: begin
                    r_neg   <= r_sum[SumW-1];
                    r_dvd   <= r_sum[SumW-1] ? SumW'(-r_sum) : r_sum;
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_state <= S_DIV;
                end

                // One quotient bit per cycle
                S_DIV: begin
                    r_rem <= div_qbit ? CountW'(div_trial - {1'b0, r_divisor})
                                      : div_trial[CountW-1:0];
                    r_dvd <= {r_dvd[SumW-2:0], div_qbit};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == DivLast) begin
                        r_state <= S_DIV_FIN;
                    end
                end

                S_DIV_FIN: begin
                    r_bias  <= r_neg ? -r_dvd[DataW-1:0] : r_dvd[DataW-1:0];
                    r_state <= S_DONE;
                end

                // Low-pass as f + w*(c - f), rounding term folded into the seed
                S_DIFF: begin
                    r_mcand  <= {{(AccW-DataW-1){diff_cf[DataW]}}, diff_cf};
                    r_mplier <= r_weight;
                    r_acc    <= {{(AccW-DataW-16){r_filt[DataW-1]}}, r_filt, 16'h8000};
                    r_op     <= OP_FILT;
                    r_bit    <= '0;
                    r_state  <= S_MUL;
                end

                // One multiplier bit per cycle
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_bit    <= r_bit + 1'b1;
                    if (r_bit == MulLast) begin
                        r_state <= S_POST;
                    end
                end

                // Finish the product just formed; after v*dt, also start the next one
                S_POST: begin
                    r_bit <= '0;
                    case (r_op)
                        OP_FILT: begin
                            r_filt  <= r_acc[DataW+15:16];
                            r_state <= S_BAND;
                        end
                        OP_DV: begin
                            r_prod  <= r_acc[SumW-1:0];
                            r_dv    <= dv_full[DataW+16:16];
                            r_state <= S_VEL;
                        end
                        OP_VDT: begin
                            r_t1     <= (r_acc <<< 1) + 64'sd65536;
                            r_mcand  <= {{(AccW-SumW){r_prod[SumW-1]}}, r_prod};
                            r_mplier <= r_step;
                            r_acc    <= '0;
                            r_op     <= OP_P2;
                            r_state  <= S_MUL;
                        end
                        default: begin
                            r_dh    <= dh_full[AccW-1:17];
                            r_state <= S_HGT;
                        end
                    endcase
                end

                // Skip integration inside the deadband
                S_BAND: begin
                    if (filt_mag >= {2'b00, r_band}) begin
                        r_mcand  <= {{(AccW-DataW){r_filt[DataW-1]}}, r_filt};
                        r_mplier <= r_step;
                        r_acc    <= '0;
                        r_op     <= OP_DV;
                        r_bit    <= '0;
                        r_state  <= S_MUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end

                // Update velocity, then form v*dt
                S_VEL: begin
                    r_vel    <= n_vel;
                    r_mcand  <= {{(AccW-DataW){n_vel[DataW-1]}}, n_vel};
                    r_mplier <= r_step;
                    r_acc    <= '0;
                    r_op     <= OP_VDT;
                    r_bit    <= '0;
                    r_state  <= S_MUL;
                end

                S_HGT: begin
                    r_hgt   <= n_hgt;
                    r_integ <= 1'b1;
                    r_state <= S_DONE;
                end

                // Hand the result to the output register when it is free
                S_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_hgt   <= r_hgt;
                        r_out_vel   <= r_vel;
                        r_out_cal   <= r_cal;
                        r_out_integ <= r_integ;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer
    `ASSERT_IMPLY(a_div_nonzero, r_state == S_DIV, r_divisor != '0, "divisor is zero")
    `ASSERT_IMPLY(a_integ_cal, r_out_valid && r_out_integ, r_out_cal, "integrated without calibration")
    `ASSERT_IMPLY(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE), "result outside done state")
    `ASSERT_NEXT(a_mul_ends, r_state == S_MUL && r_bit == MulLast, r_state == S_POST, "multiply overran")

endmodule

`default_nettype wire
